// File: design/scg_pkg.sv
// ---------------------------------------------------------------------------
// scg_pkg: shared types, constants and helpers for sign_collapse_key_groups.
// Holds the widths, the result record and the group close decision.
// ---------------------------------------------------------------------------
package scg_pkg;

    // Field widths.
    localparam int KEY_WIDTH    = 64;
    localparam int ROW_ID_WIDTH = 32;
    localparam int COUNT_WIDTH  = 32;
    localparam int SIGN_WIDTH   = 8;

    // Stream payload widths.
    localparam int IN_TDATA_WIDTH  = 104;
    localparam int OUT_TDATA_WIDTH = 40;

    // Sign codes as they appear in the row's sign column.
    localparam logic [SIGN_WIDTH-1:0] SIGN_INSERT = 8'h01;
    localparam logic [SIGN_WIDTH-1:0] SIGN_CANCEL = 8'hFF;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // One result item.
    typedef struct packed {
        logic [ROW_ID_WIDTH-1:0] kept_row_id;
        logic                    keep_row;
        logic                    count_mismatch;
        logic                    last_of_run;
    } result_t;

    // Results produced by one row: up to two, slot0 first.
    typedef struct packed {
        logic [1:0] num;
        result_t    slot0;
        result_t    slot1;
    } push_t;

    // Saturating increment of a group count.
    function automatic count_t sat_inc(input count_t c);
        sat_inc = (c == '1) ? c : c + count_t'(1);
    endfunction

    // Decision for a group that closes with the given counts.
    function automatic result_t close_result(
        input count_t                  pos,
        input count_t                  neg,
        input logic                    last_pos,
        input logic [ROW_ID_WIDTH-1:0] last_id
    );
        result_t r;
        logic    ge;
        count_t  diff;
        ge   = (pos >= neg);
        diff = ge ? (pos - neg) : (neg - pos);
        r.keep_row       = ge && last_pos;
        r.kept_row_id    = r.keep_row ? last_id : '0;
        r.count_mismatch = (diff > count_t'(1));
        r.last_of_run    = 1'b0;
        close_result     = r;
    endfunction

endpackage

// File: design/scg_group_unit.sv
// ---------------------------------------------------------------------------
// scg_group_unit: input register and group state.
// Registers an incoming row, then in one step closes the previous group on a
// key change, applies the sign and closes again on the final row.
// ---------------------------------------------------------------------------
module scg_group_unit
    import scg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [KEY_WIDTH-1:0]      row_key,
    input  logic [SIGN_WIDTH-1:0]     row_sign,
    input  logic [ROW_ID_WIDTH-1:0]   row_id,
    input  logic                      final_row,
    input  logic                      room,
    output push_t                     push
);

    logic                    in_valid_reg;
    logic [KEY_WIDTH-1:0]    key_reg;
    logic [SIGN_WIDTH-1:0]   sign_reg;
    logic [ROW_ID_WIDTH-1:0] id_reg;
    logic                    fin_reg;

    logic [KEY_WIDTH-1:0]    group_key_reg,   group_key_next;
    logic                    group_open_reg,  group_open_next;
    count_t                  pos_reg,         pos_next;
    count_t                  neg_reg,         neg_next;
    logic [ROW_ID_WIDTH-1:0] lpr_reg,         lpr_next;
    logic                    lwp_reg,         lwp_next;

    logic    proc;
    logic    new_group;
    logic    emit_a;
    logic    emit_b;
    result_t res_a;
    result_t res_b;
    count_t  pos1, neg1, pos2, neg2;
    logic [ROW_ID_WIDTH-1:0] lpr1, lpr2;
    logic    lwp2;

    // The held row is processed when the queue has room for two results.
    assign proc     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || room;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            key_reg  <= row_key;
            sign_reg <= row_sign;
            id_reg   <= row_id;
            fin_reg  <= final_row;
        end
    end

    // Group update and close decisions.
    always_comb
    begin
        new_group = !group_open_reg || (key_reg != group_key_reg);

        // Close the previous group on a key change.
        emit_a = new_group && ((pos_reg != '0) || (neg_reg != '0));
        res_a  = close_result(pos_reg, neg_reg, lwp_reg, lpr_reg);
        pos1   = new_group ? count_t'(0) : pos_reg;
        neg1   = new_group ? count_t'(0) : neg_reg;
        lpr1   = emit_a ? '0 : lpr_reg;

        // Apply the sign; other values leave the group as it is.
        pos2 = pos1;
        neg2 = neg1;
        lpr2 = lpr1;
        lwp2 = lwp_reg;
        if (sign_reg == SIGN_INSERT)
        begin
            pos2 = sat_inc(pos1);
            lpr2 = id_reg;
            lwp2 = 1'b1;
        end
        else if (sign_reg == SIGN_CANCEL)
        begin
            neg2 = sat_inc(neg1);
            lwp2 = 1'b0;
        end

        // Close again after the final row.
        emit_b = fin_reg && ((pos2 != '0) || (neg2 != '0));
        res_b  = close_result(pos2, neg2, lwp2, lpr2);
        res_b.last_of_run = 1'b1;
        res_a.last_of_run = !emit_b;

        group_key_next  = new_group ? key_reg : group_key_reg;
        group_open_next = !fin_reg;
        pos_next        = fin_reg ? count_t'(0) : pos2;
        neg_next        = fin_reg ? count_t'(0) : neg2;
        lpr_next        = emit_b ? '0 : lpr2;
        lwp_next        = lwp2;

        // Pack the results, the earlier close first.
        push.num   = proc ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
        push.slot0 = emit_a ? res_a : res_b;
        push.slot1 = res_b;
    end

    // Group state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_key_reg  <= '0;
            group_open_reg <= 1'b0;
            pos_reg        <= '0;
            neg_reg        <= '0;
            lpr_reg        <= '0;
            lwp_reg        <= 1'b0;
        end
        else if (proc)
        begin
            group_key_reg  <= group_key_next;
            group_open_reg <= group_open_next;
            pos_reg        <= pos_next;
            neg_reg        <= neg_next;
            lpr_reg        <= lpr_next;
            lwp_reg        <= lwp_next;
        end
    end

endmodule

// File: design/scg_result_fifo.sv
// ---------------------------------------------------------------------------
// scg_result_fifo: small result queue.
// Takes up to two results per cycle and hands out one per transaction.
// ---------------------------------------------------------------------------
module scg_result_fifo
    import scg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t            mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               pop;

    assign room      = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.num);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.num) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage writes, one or two entries.
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.slot0;
        end
        if (push.num == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.slot1;
        end
    end

endmodule

// File: design/sign_collapse_key_groups.sv
// ---------------------------------------------------------------------------
// sign_collapse_key_groups: collapses a key-ordered row stream by sign.
// Counts inserts and cancels per run of equal keys and reports, per closed
// group, whether its last inserted row survives and whether counts mismatch.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   s_*       in         tdata: row_key, row_sign, row_id; tlast: final_row
//   m_*       out        tdata: kept_row_id, keep_row, count_mismatch;
//                        tlast: last_of_run
//
// A row is registered on acceptance and processed when the result queue
// has room; its results are written into that queue and leave on m_*.
// One row per cycle is sustained while the queue has room; the output port
// moves one result per cycle, so a row that closes two groups sends both in turn.
// A held row is processed, and the next one accepted, only while the
// four-entry result queue can take two more results; an empty row register
// always accepts. Backpressure on m_* propagates through that queue.
// Reset clears the group state and the queue; no group is open after reset.
// ---------------------------------------------------------------------------
module sign_collapse_key_groups
    import scg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [63:0] row_key, [71:64] row_sign, [103:72] row_id
    input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [31:0] kept_row_id, [32] keep_row, [33] count_mismatch, [39:34] zero
    output logic [OUT_TDATA_WIDTH-1:0] m_tdata,
    output logic                       m_tlast
);

    push_t   push;
    logic    room;
    result_t res;

    // Group tracking.
    scg_group_unit u_group
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .row_key   (s_tdata[KEY_WIDTH-1:0]),
        .row_sign  (s_tdata[KEY_WIDTH +: SIGN_WIDTH]),
        .row_id    (s_tdata[KEY_WIDTH+SIGN_WIDTH +: ROW_ID_WIDTH]),
        .final_row (s_tlast),
        .room      (room),
        .push      (push)
    );

    // Result queue.
    scg_result_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // Output packing.
    assign m_tdata = {(OUT_TDATA_WIDTH-ROW_ID_WIDTH-2)'(0), res.count_mismatch,
                      res.keep_row, res.kept_row_id};
    assign m_tlast = res.last_of_run;

endmodule
